[src/hts_pkg.sv]
// Package for the Hall trigger-wheel sync decoder and spark timer.
// Holds widths, wheel constants, register and command codes, and the
// controller/datapath command and status structs. No dependencies.
package hts_pkg;

  // Wheel geometry and timing constants.
  localparam int          COGS       = 3;
  localparam int          START_SKIP = 2;
  localparam logic [15:0] SPARK_MIN  = 16'd15;
  localparam logic [15:0] CAL_DELAY  = 16'd2;

  // Field widths.
  localparam int TIME_W  = 16;
  localparam int ANGLE_W = 15;
  localparam int COG_W   = 8;
  localparam int PROD_W  = ANGLE_W + TIME_W;

  // The divider retires one quotient bit per cycle over the full product.
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ADVANCE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_STROKE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_BEGIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOCK_ENABLE   = 3'd4;

  localparam logic [TIME_W-1:0] DEG_PER_STROKE_RST = 16'd5760;

  // Input operation codes.
  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Which scaled delay the shared multiply/divide unit is working on.
  localparam logic [1:0] SEL_SPARK = 2'd0;
  localparam logic [1:0] SEL_OPEN  = 2'd1;
  localparam logic [1:0] SEL_LEN   = 2'd2;

  typedef struct packed {
    logic       accept_edge;
    logic       accept_tick;
    logic       mul_load;
    logic       div_step;
    logic       store;
    logic       out_load;
    logic [1:0] sel;
  } hts_cmd_t;

  typedef struct packed {
    logic stroke;
    logic knock;
  } hts_status_t;

endpackage

[src/hts_if.sv]
// Channel interfaces of the sync decoder: input beats, result beats and
// configuration writes, each with a valid/ready handshake. Uses hts_pkg.
interface hts_in_if import hts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [TIME_W-1:0] timestamp;

  modport source (output valid, output operation, output timestamp, input ready);
  modport sink   (input valid, input operation, input timestamp, output ready);
endinterface

interface hts_out_if import hts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              stroke_event;
  logic              sync_error;
  logic              in_sync;
  logic [TIME_W-1:0] period_out;
  logic              period_wrapped;
  logic [7:0]        overflow_snapshot;
  logic [TIME_W-1:0] spark_compare;
  logic [COG_W-1:0]  spark_channel;
  logic              knock_valid;
  logic [TIME_W-1:0] knock_open_delay;
  logic [TIME_W-1:0] knock_length_delay;

  modport source (
    output valid, output stroke_event, output sync_error, output in_sync,
    output period_out, output period_wrapped, output overflow_snapshot,
    output spark_compare, output spark_channel, output knock_valid,
    output knock_open_delay, output knock_length_delay, input ready
  );
  modport sink (
    input valid, input stroke_event, input sync_error, input in_sync,
    input period_out, input period_wrapped, input overflow_snapshot,
    input spark_compare, input spark_channel, input knock_valid,
    input knock_open_delay, input knock_length_delay, output ready
  );
endinterface

interface hts_cfg_if import hts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

[src/hts_datapath.sv]
// Datapath of the sync decoder: configuration registers, wheel decode state,
// shared multiplier and bit-serial divider, and the result register.
// Depends on hts_pkg; driven by hts_controller commands.
module hts_datapath import hts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hts_cmd_t              cmd,
  output hts_status_t           sts,
  input  logic                  cfg_fire,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TIME_W-1:0]     in_timestamp,
  output logic                  o_stroke_event,
  output logic                  o_sync_error,
  output logic                  o_in_sync,
  output logic [TIME_W-1:0]     o_period_out,
  output logic                  o_period_wrapped,
  output logic [7:0]            o_overflow_snapshot,
  output logic [TIME_W-1:0]     o_spark_compare,
  output logic [COG_W-1:0]      o_spark_channel,
  output logic                  o_knock_valid,
  output logic [TIME_W-1:0]     o_knock_open_delay,
  output logic [TIME_W-1:0]     o_knock_length_delay
);

  // Configuration.
  logic [ANGLE_W-1:0] advance_offset_r;
  logic [TIME_W-1:0]  deg_per_stroke_r;
  logic [ANGLE_W-1:0] knock_begin_r;
  logic [ANGLE_W-1:0] knock_width_r;
  logic               knock_enable_r;

  // Wheel decode state.
  logic [TIME_W-1:0] prev_edge_r, prev_edge_nxt;
  logic [TIME_W-1:0] stroke_start_r, stroke_start_nxt;
  logic [TIME_W-1:0] prev_period_r, prev_period_nxt;
  logic [TIME_W-1:0] stroke_period_r, stroke_period_nxt;
  logic              wrap_r, wrap_nxt;
  logic [COG_W-1:0]  cog_r, cog_nxt;
  logic [7:0]        ovf_cnt_r, ovf_cnt_nxt;
  logic [7:0]        ovf_latch_r, ovf_latch_nxt;
  logic              synced_r, synced_nxt;
  logic              crank_r, crank_nxt;
  logic              pvalid_r, pvalid_nxt;

  // Per-edge working registers.
  logic              stroke_r, err_r, kvalid_r;
  logic [COG_W-1:0]  chan_r;
  logic [TIME_W-1:0] tmr_r;
  logic [TIME_W-1:0] spark_r, kopen_r, klen_r;

  // Multiply/divide unit.
  logic [PROD_W-1:0] dvd_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] quo_r;

  // Edge decode.
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] thr;
  logic              gap;
  logic              skip, enter, err, stroke;
  logic [COG_W-1:0]  cog_w;

  assign period = in_timestamp - prev_edge_r;
  assign thr    = (prev_period_r >> 2) + (prev_period_r >> 3);
  assign gap    = thr > period;

  always_comb begin
    skip              = 1'b0;
    enter             = 1'b0;
    err               = 1'b0;
    cog_w             = cog_r;
    synced_nxt        = synced_r;
    crank_nxt         = crank_r;
    stroke_period_nxt = stroke_period_r;
    wrap_nxt          = wrap_r;
    ovf_latch_nxt     = ovf_latch_r;
    ovf_cnt_nxt       = ovf_cnt_r;
    pvalid_nxt        = pvalid_r;
    stroke_start_nxt  = stroke_start_r;
    if (!synced_r) begin
      if (!crank_r) begin
        if (cog_r >= COG_W'(START_SKIP)) begin
          crank_nxt = 1'b1;
        end
        skip = 1'b1;
      end else if (gap) begin
        synced_nxt = 1'b1;
        cog_w      = COG_W'(1);
        enter      = 1'b1;
      end
    end
    if (!skip && !enter) begin
      if (gap) begin
        err   = (cog_w != COG_W'(COGS + 1));
        cog_w = COG_W'(1);
      end
      if (cog_w == COG_W'(COGS)) begin
        skip = 1'b1;
      end
    end
    stroke = !skip;
    if (stroke) begin
      if (pvalid_r) begin
        stroke_period_nxt = in_timestamp - stroke_start_r;
        wrap_nxt          = in_timestamp < stroke_start_r;
        ovf_latch_nxt     = ovf_cnt_r;
        ovf_cnt_nxt       = '0;
      end
      pvalid_nxt       = 1'b1;
      stroke_start_nxt = in_timestamp;
    end
    cog_nxt         = cog_w + COG_W'(1);
    prev_edge_nxt   = in_timestamp;
    prev_period_nxt = period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      advance_offset_r <= '0;
      deg_per_stroke_r <= DEG_PER_STROKE_RST;
      knock_begin_r    <= '0;
      knock_width_r    <= '0;
      knock_enable_r   <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_ADVANCE_OFFSET: advance_offset_r <= cfg_data[ANGLE_W-1:0];
        REG_DEG_PER_STROKE: deg_per_stroke_r <= cfg_data[TIME_W-1:0];
        REG_KNOCK_BEGIN:    knock_begin_r    <= cfg_data[ANGLE_W-1:0];
        REG_KNOCK_WIDTH:    knock_width_r    <= cfg_data[ANGLE_W-1:0];
        REG_KNOCK_ENABLE:   knock_enable_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_edge_r     <= '0;
      stroke_start_r  <= '0;
      prev_period_r   <= '0;
      stroke_period_r <= '1;
      wrap_r          <= 1'b0;
      cog_r           <= COG_W'(1);
      ovf_cnt_r       <= '0;
      ovf_latch_r     <= 8'd255;
      synced_r        <= 1'b0;
      crank_r         <= 1'b0;
      pvalid_r        <= 1'b0;
      stroke_r        <= 1'b0;
      kvalid_r        <= 1'b0;
    end else if (cmd.accept_tick) begin
      ovf_cnt_r <= ovf_cnt_r + 8'd1;
    end else if (cmd.accept_edge) begin
      prev_edge_r     <= prev_edge_nxt;
      stroke_start_r  <= stroke_start_nxt;
      prev_period_r   <= prev_period_nxt;
      stroke_period_r <= stroke_period_nxt;
      wrap_r          <= wrap_nxt;
      cog_r           <= cog_nxt;
      ovf_cnt_r       <= ovf_cnt_nxt;
      ovf_latch_r     <= ovf_latch_nxt;
      synced_r        <= synced_nxt;
      crank_r         <= crank_nxt;
      pvalid_r        <= pvalid_nxt;
      stroke_r        <= stroke;
      kvalid_r        <= stroke & knock_enable_r;
    end
  end

  // Divider step: shift one dividend bit into the remainder and subtract.
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              q_bit;
  logic [ANGLE_W-1:0] angle;
  logic [TIME_W-1:0] quot;
  logic [TIME_W-1:0] spark_d;

  assign rem_sh  = {rem_r, dvd_r[PROD_W-1]};
  assign rem_sub = rem_sh - {1'b0, deg_per_stroke_r};
  assign q_bit   = rem_sh >= {1'b0, deg_per_stroke_r};
  assign quot    = (deg_per_stroke_r == '0) ? '1 : quo_r;
  assign spark_d = (quot < SPARK_MIN) ? SPARK_MIN : quot;

  always_comb begin
    case (cmd.sel)
      SEL_SPARK: angle = advance_offset_r;
      SEL_OPEN:  angle = knock_begin_r;
      SEL_LEN:   angle = knock_width_r;
      default:   angle = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_edge) begin
      err_r   <= err;
      chan_r  <= stroke ? (cog_w - COG_W'(1)) : '0;
      tmr_r   <= in_timestamp;
      spark_r <= '0;
      kopen_r <= '0;
      klen_r  <= '0;
    end
    if (cmd.mul_load) begin
      dvd_r <= PROD_W'(angle) * PROD_W'(stroke_period_r);
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[PROD_W-2:0], 1'b0};
      rem_r <= q_bit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      quo_r <= {quo_r[TIME_W-2:0], q_bit};
    end
    if (cmd.store) begin
      case (cmd.sel)
        SEL_SPARK: spark_r <= tmr_r + spark_d - CAL_DELAY;
        SEL_OPEN:  kopen_r <= quot;
        SEL_LEN:   klen_r  <= quot;
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_stroke_event       <= stroke_r;
      o_sync_error         <= err_r;
      o_in_sync            <= synced_r;
      o_period_out         <= stroke_period_r;
      o_period_wrapped     <= wrap_r;
      o_overflow_snapshot  <= ovf_latch_r;
      o_spark_compare      <= spark_r;
      o_spark_channel      <= chan_r;
      o_knock_valid        <= kvalid_r;
      o_knock_open_delay   <= kopen_r;
      o_knock_length_delay <= klen_r;
    end
  end

  assign sts.stroke = stroke_r;
  assign sts.knock  = kvalid_r;

endmodule

[src/hts_controller.sv]
// Controller of the sync decoder: sequences decode, multiply, divide and
// result hand-off, and owns the channel handshakes. Depends on hts_pkg.
module hts_controller import hts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_operation,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  hts_status_t sts,
  output hts_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_STORE = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              in_fire;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_TICK) begin
            cmd.accept_tick = 1'b1;
          end else begin
            cmd.accept_edge = 1'b1;
            state_nxt       = S_DEC;
          end
        end
      end
      S_DEC: begin
        sel_nxt   = SEL_SPARK;
        state_nxt = sts.stroke ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_STORE;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (sel_r == SEL_SPARK && sts.knock) begin
          sel_nxt   = SEL_OPEN;
          state_nxt = S_MUL;
        end else if (sel_r == SEL_OPEN) begin
          sel_nxt   = SEL_LEN;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_SPARK;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A held result is never overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> out_free)
    else $error("result register loaded while a beat is still held");

  // A sensor edge always goes to decode; a timer tick never leaves idle.
  a_edge_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_EDGE) |=> state_r == S_DEC)
    else $error("sensor edge accepted without decode");
  a_tick_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == OP_TICK) |=> state_r == S_IDLE)
    else $error("timer tick left the idle state");

  // The divider step stays within its count and the knock delays need knock.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> step_r <= STEP_W'(DIV_STEPS - 1))
    else $error("divider step count out of range");
  a_knock_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && sel_r != SEL_SPARK) |-> sts.knock)
    else $error("knock delay computed with knock disabled");

endmodule

[src/hall_trigger_sync_spark_timer.sv]
// Top level of the Hall trigger-wheel sync decoder and spark timer.
// Joins hts_controller and hts_datapath; uses hts_pkg and the hts_if channels.
//
// Usage. The in_ch channel takes one beat per event: operation 0 is a Hall
// sensor edge with its captured timestamp, operation 1 a timer overflow tick.
// A tick only advances the overflow counter and returns no result. Every
// sensor edge returns exactly one beat on out_ch with sync status, the stroke
// period, wrap sign, overflow snapshot and, on a stroke edge, the spark compare
// time, channel and (when knock_enable is set) the knock-window delays.
// The cfg_ch channel writes the five setup registers by index; it is always
// ready and must only be used while no edge is in flight.
//
// Timing. A tick is taken without leaving idle. An edge that does not start a
// stroke goes from decode straight to the finish state. A stroke edge runs the
// shared 15x16 multiplier and a one-bit-per-cycle restoring divider once per
// scaled delay, once without knock and three times with knock; one edge is
// worked on at a time. A finished result sits in an output register, so the
// block returns to idle and takes further beats as soon as it is loaded; if
// the receiver stalls with a result still held, the next edge waits before
// its own hand-off. Reset (rst_n low, synchronous) restores the register
// defaults and the decode state, and drops out_ch.valid.
module hall_trigger_sync_spark_timer import hts_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  hts_in_if.sink    in_ch,
  hts_out_if.source out_ch,
  hts_cfg_if.sink   cfg_ch
);

  hts_cmd_t    cmd;
  hts_status_t sts;
  logic        cfg_fire;

  // Configuration writes land in a single register stage.
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;

  hts_controller u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  hts_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_fire             (cfg_fire),
    .cfg_index            (cfg_ch.reg_index),
    .cfg_data             (cfg_ch.wdata),
    .in_timestamp         (in_ch.timestamp),
    .o_stroke_event       (out_ch.stroke_event),
    .o_sync_error         (out_ch.sync_error),
    .o_in_sync            (out_ch.in_sync),
    .o_period_out         (out_ch.period_out),
    .o_period_wrapped     (out_ch.period_wrapped),
    .o_overflow_snapshot  (out_ch.overflow_snapshot),
    .o_spark_compare      (out_ch.spark_compare),
    .o_spark_channel      (out_ch.spark_channel),
    .o_knock_valid        (out_ch.knock_valid),
    .o_knock_open_delay   (out_ch.knock_open_delay),
    .o_knock_length_delay (out_ch.knock_length_delay)
  );

endmodule
